>>> design/fpa_pkg.sv
// Shared constants, types and helper functions of the frame pool allocator.
`default_nettype none

package fpa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int SHIFT_W    = 5;
    localparam int CFG_W      = COUNT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int OFF_W      = 64;
    localparam int LEN_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int OWN_W      = 2;
    localparam int SHIFT_LO   = 6;
    localparam int SHIFT_HI   = 16;
    localparam int AREA_W     = COUNT_W + SHIFT_HI;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b1;

    // Request codes
    localparam logic [1:0] FN_ALLOC_RX = 2'd0;
    localparam logic [1:0] FN_ALLOC_TX = 2'd1;
    localparam logic [1:0] FN_REL_TX   = 2'd2;
    localparam logic [1:0] FN_REL_RX   = 2'd3;

    // Owner marks
    localparam logic [OWN_W-1:0] OWN_FREE = 2'd0;
    localparam logic [OWN_W-1:0] OWN_TX   = 2'd1;
    localparam logic [OWN_W-1:0] OWN_RX   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOF   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OWNER = 3'd4;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_FRAMES);

    typedef struct packed {
        logic clear_restart;
        logic clear_en;
        logic load_in;
        logic read_en;
        logic commit;
    } fpa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } fpa_stat_t;

    function automatic logic [SHIFT_W-1:0] sat_shift(input logic [SHIFT_W-1:0] v);
        logic [SHIFT_W-1:0] r;
        r = v;
        if (v < SHIFT_W'(SHIFT_LO))
            r = SHIFT_W'(SHIFT_LO);
        else if (v > SHIFT_W'(SHIFT_HI))
            r = SHIFT_W'(SHIFT_HI);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = v;
        if (v == '0)
            r = COUNT_W'(1);
        else if (v > COUNT_W'(MAX_FRAMES))
            r = COUNT_W'(MAX_FRAMES);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/frame_pool_allocator_checked_top.sv
// Top level of the frame pool allocator with checked release.
//
//  channel   direction  handshake            payload
//  in        inbound    in_valid / in_stall  func, rel_offset, length
//  out       outbound   out_valid/out_stall  granted_offset, status, free_frames
//  cfg       inbound    cfg_we (no wait)     cfg_index, cfg_data
//
// A transaction has a read stage, which reads the free stack and owner map
// (registered reads, checks computed alongside), and a commit stage that
// writes the update; the commit depends on the registered memory read data.
// A new transaction is taken in the cycle the previous one commits.
// After reset and after every register write, a clearing pass refills the
// stack and marks all 4096 frames free; the input stalls meanwhile.
// A stalled result holds in the output register; the write stage waits for it.
`default_nettype none

module frame_pool_allocator_checked_top
    import fpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    input  wire logic [OFF_W-1:0]     rel_offset,
    input  wire logic [LEN_W-1:0]     length,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [OFF_W-1:0]          granted_offset,
    output logic [STATUS_W-1:0]       status,
    output logic [COUNT_W-1:0]        free_frames,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    fpa_cmd_t  cmd;
    fpa_stat_t dp_stat;

    // Sequencer: clear sweep, read stage, commit stage
    fpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    // Memories, checks, free count and result register
    fpa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .dp_stat        (dp_stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .rel_offset     (rel_offset),
        .length         (length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted_offset (granted_offset),
        .status         (status),
        .free_frames    (free_frames)
    );

endmodule

`default_nettype wire

>>> design/fpa_ctrl.sv
// Sequencing state machine of the frame pool allocator.
`default_nettype none

module fpa_ctrl
    import fpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire logic      cfg_we,
    input  wire fpa_stat_t dp_stat,
    output fpa_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_WRITE = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    // Take a new transaction when idle or in the cycle that retires the current one
    always_comb
    begin
        in_stall = !((state_reg == S_IDLE) ||
                     ((state_reg == S_WRITE) && dp_stat.out_free));
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        cmd.clear_restart = cfg_we;
        cmd.clear_en      = (state_reg == S_CLEAR);
        cmd.load_in       = accept;
        cmd.read_en       = (state_reg == S_READ);
        cmd.commit        = (state_reg == S_WRITE) && dp_stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (dp_stat.clear_last)
                        state_next = S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                        state_next = S_READ;
                end
                S_READ:
                begin
                    state_next = S_WRITE;
                end
                S_WRITE:
                begin
                    if (dp_stat.out_free)
                        state_next = accept ? S_READ : S_IDLE;
                end
                default:
                begin
                    state_next = S_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> design/fpa_dp.sv
// Datapath of the frame pool allocator: registers, memories, checks and result register.
`default_nettype none

module fpa_dp
    import fpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpa_cmd_t             cmd,
    output fpa_stat_t                 dp_stat,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [1:0]           func,
    input  wire logic [OFF_W-1:0]     rel_offset,
    input  wire logic [LEN_W-1:0]     length,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [OFF_W-1:0]          granted_offset,
    output logic [STATUS_W-1:0]       status,
    output logic [COUNT_W-1:0]        free_frames
);

    logic [FRAME_W-1:0] stack_mem [MAX_FRAMES];
    logic [OWN_W-1:0]   owner_mem [MAX_FRAMES];

    logic [SHIFT_W-1:0]  shift_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  fc_reg;
    logic [COUNT_W-1:0]  fc_next;
    logic [FRAME_W-1:0]  clr_reg;

    logic [1:0]          func_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [LEN_W-1:0]    len_reg;

    logic [FRAME_W-1:0]  stk_rd_reg;
    logic [OWN_W-1:0]    own_rd_reg;
    logic [FRAME_W-1:0]  fr_rel_reg;
    logic                len_zero_reg;
    logic                cross_reg;
    logic                range_reg;

    logic                out_valid_reg;
    logic [OFF_W-1:0]    granted_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  free_reg;

    logic [OFF_W-1:0]    last_byte;
    logic [OFF_W-1:0]    span_diff;
    logic [AREA_W-1:0]   area;
    logic [FRAME_W-1:0]  fr_rel;
    logic [FRAME_W-1:0]  stk_rd_addr;

    logic                alloc;
    logic                pop;
    logic                push;
    logic [OWN_W-1:0]    want;
    logic [STATUS_W-1:0] res_status;
    logic [OFF_W-1:0]    res_granted;

    assign dp_stat.clear_last = (clr_reg == FRAME_W'(MAX_FRAMES - 1));
    assign dp_stat.out_free   = !out_valid_reg || !out_stall;

    // Configuration, stored already saturated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_SHIFT: shift_reg <= sat_shift(cfg_data[SHIFT_W-1:0]);
                CFG_FRAME_COUNT: count_reg <= sat_count(cfg_data[COUNT_W-1:0]);
                default:         shift_reg <= shift_reg;
            endcase
        end
    end

    // Clear sweep index; wraps to zero after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_restart)
            clr_reg <= '0;
        else if (cmd.clear_en)
            clr_reg <= clr_reg + FRAME_W'(1);
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            off_reg  <= rel_offset;
            len_reg  <= length;
        end
    end

    // Read stage: release checks and memory addresses
    always_comb
    begin
        last_byte   = off_reg + OFF_W'(len_reg) - OFF_W'(1);
        span_diff   = off_reg ^ last_byte;
        area        = AREA_W'(count_reg) << shift_reg;
        fr_rel      = FRAME_W'(off_reg >> shift_reg);
        stk_rd_addr = fc_reg[FRAME_W-1:0] - FRAME_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            stk_rd_reg   <= stack_mem[stk_rd_addr];
            own_rd_reg   <= owner_mem[fr_rel];
            fr_rel_reg   <= fr_rel;
            len_zero_reg <= (len_reg == '0);
            cross_reg    <= ((span_diff >> shift_reg) != '0);
            range_reg    <= (off_reg >= OFF_W'(area));
        end
    end

    // Write stage: decide and update
    always_comb
    begin
        alloc       = !func_reg[1];
        want        = (func_reg == FN_REL_TX) ? OWN_TX : OWN_RX;
        pop         = 1'b0;
        push        = 1'b0;
        res_status  = ST_OK;
        res_granted = '1;
        if (alloc)
        begin
            if (fc_reg == '0)
            begin
                res_status = ST_OOF;
            end
            else
            begin
                pop         = 1'b1;
                res_granted = OFF_W'(stk_rd_reg) << shift_reg;
            end
        end
        else
        begin
            priority if ((func_reg == FN_REL_RX) && len_zero_reg)
                res_status = ST_LEN;
            else if ((func_reg == FN_REL_RX) && cross_reg)
                res_status = ST_LEN;
            else if (range_reg)
                res_status = ST_RANGE;
            else if ((own_rd_reg != want) || (fc_reg >= count_reg))
                res_status = ST_OWNER;
            else
                push = 1'b1;
        end
    end

    always_comb
    begin
        fc_next = fc_reg;
        if (cmd.clear_en)
            fc_next = count_reg;
        else if (cmd.commit && pop)
            fc_next = fc_reg - COUNT_W'(1);
        else if (cmd.commit && push)
            fc_next = fc_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fc_reg <= COUNT_RESET;
        else
            fc_reg <= fc_next;
    end

    // Memory writes: clear sweep, or the committed pop or push
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            stack_mem[clr_reg] <= clr_reg;
            owner_mem[clr_reg] <= OWN_FREE;
        end
        else if (cmd.commit && pop)
        begin
            owner_mem[stk_rd_reg] <= (func_reg == FN_ALLOC_RX) ? OWN_RX : OWN_TX;
        end
        else if (cmd.commit && push)
        begin
            stack_mem[fc_reg[FRAME_W-1:0]] <= fr_rel_reg;
            owner_mem[fr_rel_reg]          <= OWN_FREE;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            granted_reg <= res_granted;
            status_reg  <= res_status;
            free_reg    <= fc_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_offset = granted_reg;
    assign status         = status_reg;
    assign free_frames    = free_reg;

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= COUNT_W'(MAX_FRAMES))
        else $error("free count above pool size");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result written over a waiting result");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && pop) |=> (fc_reg == $past(fc_reg) - COUNT_W'(1)))
        else $error("allocation did not lower the free count");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

`default_nettype wire

>>> tb/sv/frame_pool_allocator_checked_top_test.sv
// Self-checking testbench for the frame pool allocator with checked release.
module frame_pool_allocator_checked_top_test
    import fpa_pkg::*;
();

    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int PHASE_ITEMS    = 240;
    localparam int RANDOM_PHASES  = 8;

    // One predicted answer of the pool, field for field as on the result port
    typedef struct packed {
        logic [OFF_W-1:0]    granted;
        logic [STATUS_W-1:0] code;
        logic [COUNT_W-1:0]  frames_left;
    } pool_answer_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [1:0]           func         = FN_ALLOC_RX;
    logic [OFF_W-1:0]     rel_offset   = '0;
    logic [LEN_W-1:0]     length       = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [OFF_W-1:0]     granted_offset;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   free_frames;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_FRAME_SHIFT;
    logic [CFG_W-1:0]     cfg_data     = '0;

    always
    begin
        #CLK_LOW clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    frame_pool_allocator_checked_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .rel_offset     (rel_offset),
        .length         (length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted_offset (granted_offset),
        .status         (status),
        .free_frames    (free_frames),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // Pool predictor: its own copy of the registers, free stack and owner
    // marks. Every accepted request is run through pool_answer in order.
    // ------------------------------------------------------------------
    logic [SHIFT_W-1:0] cfg_shift_value = SHIFT_RESET;
    logic [COUNT_W-1:0] cfg_count_value = COUNT_RESET;
    logic [FRAME_W-1:0] free_frame_stack [MAX_FRAMES];
    logic [OWN_W-1:0]   owner_mark       [MAX_FRAMES];
    logic [COUNT_W-1:0] free_total;

    pool_answer_t pending_answers [$];
    int           mismatch_count = 0;
    int           burst_left     = 0;

    // Clamp the frame size exponent into the supported span
    function automatic int frame_shift_used();
        int used;
        used = int'(cfg_shift_value);
        if (used < SHIFT_LO)
            used = SHIFT_LO;
        if (used > SHIFT_HI)
            used = SHIFT_HI;
        return used;
    endfunction

    // Clamp the frame count to at least one and at most the memory depth
    function automatic int frame_count_used();
        int used;
        used = int'(cfg_count_value);
        if (used == 0)
            used = 1;
        if (used > MAX_FRAMES)
            used = MAX_FRAMES;
        return used;
    endfunction

    // Refill the stack in frame order and mark everything free
    function automatic void refill_pool();
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            free_frame_stack[i] = FRAME_W'(i);
            owner_mark[i]       = OWN_FREE;
        end
        free_total = COUNT_W'(frame_count_used());
    endfunction

    function automatic pool_answer_t pool_answer(input logic [1:0] fn,
                                                 input logic [OFF_W-1:0] off,
                                                 input logic [LEN_W-1:0] len);
        pool_answer_t       ans;
        int                 sh;
        int                 cnt;
        logic [OFF_W-1:0]   area;
        logic [OFF_W-1:0]   mask;
        logic [OFF_W-1:0]   last_byte;
        logic [OFF_W-1:0]   frame_num;
        logic [FRAME_W-1:0] fr;
        logic [OWN_W-1:0]   want;
        sh          = frame_shift_used();
        cnt         = frame_count_used();
        area        = OFF_W'(cnt) << sh;
        mask        = ~((64'd1 << sh) - 64'd1);
        ans.granted = '1;
        ans.code    = ST_OK;
        if (fn == FN_ALLOC_RX || fn == FN_ALLOC_TX)
        begin
            if (free_total == '0)
                ans.code = ST_OOF;
            else
            begin
                // Pop the top of the stack and hand the frame to its new owner
                free_total         = free_total - COUNT_W'(1);
                fr                 = free_frame_stack[free_total];
                owner_mark[fr]     = (fn == FN_ALLOC_RX) ? OWN_RX : OWN_TX;
                ans.granted        = OFF_W'(fr) << sh;
            end
        end
        else
        begin
            want      = (fn == FN_REL_TX) ? OWN_TX : OWN_RX;
            last_byte = off + OFF_W'(len) - 64'd1;
            if (fn == FN_REL_RX && len == '0)
                ans.code = ST_LEN;
            else if (fn == FN_REL_RX && (off & mask) != (last_byte & mask))
                ans.code = ST_LEN;
            else if (off >= area)
                ans.code = ST_RANGE;
            else
            begin
                frame_num = off >> sh;
                fr        = frame_num[FRAME_W-1:0];
                if (frame_num >= OFF_W'(cnt) || owner_mark[fr] != want ||
                    int'(free_total) >= cnt)
                    ans.code = ST_OWNER;
                else
                begin
                    // Push the frame back and clear its owner mark
                    free_frame_stack[free_total] = fr;
                    owner_mark[fr]               = OWN_FREE;
                    free_total                   = free_total + COUNT_W'(1);
                end
            end
        end
        ans.frames_left = free_total;
        return ans;
    endfunction

    // Pick a random frame of the live area that carries the given mark, or -1
    function automatic int find_marked(input logic [OWN_W-1:0] mark);
        int cnt;
        int start;
        int found;
        int f;
        cnt   = frame_count_used();
        start = $urandom_range(0, cnt - 1);
        found = -1;
        for (int k = 0; k < cnt && found < 0; k++)
        begin
            f = (start + k) % cnt;
            if (owner_mark[f] == mark)
                found = f;
        end
        return found;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall on one of four patterns, picked anew at random,
    // and compare every accepted transaction with the oldest prediction.
    // ------------------------------------------------------------------
    stall_kind_t stall_kind  = STALL_NONE;
    int          stall_left  = 0;
    int          stall_phase = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_kind = stall_kind_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        stall_phase++;
        case (stall_kind)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 99) < 70);
            default:      out_stall <= (stall_phase % 4 != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_answer
        pool_answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (granted_offset !== want.granted)
                begin
                    $error("granted_offset: expected %h, got %h", want.granted, granted_offset);
                    mismatch_count++;
                end
                if (status !== want.code)
                begin
                    $error("status: expected %0d, got %0d", want.code, status);
                    mismatch_count++;
                end
                if (free_frames !== want.frames_left)
                begin
                    $error("free_frames: expected %0d, got %0d", want.frames_left, free_frames);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request transaction. Bursts of random length are separated by
    // random gaps; hold the payload until the block takes it, then predict.
    task automatic send_request(input logic [1:0] fn, input logic [OFF_W-1:0] off,
                                input logic [LEN_W-1:0] len);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid     <= 1'b1;
        func         <= fn;
        rel_offset   <= off;
        length       <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_answers.push_back(pool_answer(fn, off, len));
    endtask

    // Drop valid and let every outstanding result drain, plus a short margin
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register once the block is idle; any write refills the pool
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FRAME_SHIFT)
            cfg_shift_value = value[SHIFT_W-1:0];
        else
            cfg_count_value = value;
        refill_pool();
    endtask

    // One random request, mostly well-formed allocate/release traffic on
    // frames that are really held, the rest broken or pure noise
    task automatic random_request();
        int               pick;
        int               fr;
        int               sh;
        int               cnt;
        logic [OFF_W-1:0] fsize;
        logic [OFF_W-1:0] inner;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [1:0]       fn;
        sh    = frame_shift_used();
        cnt   = frame_count_used();
        fsize = 64'd1 << sh;
        inner = OFF_W'($urandom_range(0, 32'(fsize - 64'd1)));
        off   = {$urandom, $urandom};
        len   = $urandom;
        pick  = $urandom_range(0, 99);
        fn    = $urandom_range(0, 1) ? FN_ALLOC_TX : FN_ALLOC_RX;
        if (pick >= 35 && pick < 65)
        begin
            // Release a held frame with the matching function and a span
            // that stays inside the frame
            fn = $urandom_range(0, 1) ? FN_REL_TX : FN_REL_RX;
            fr = find_marked((fn == FN_REL_TX) ? OWN_TX : OWN_RX);
            if (fr < 0)
                fn = $urandom_range(0, 1) ? FN_ALLOC_TX : FN_ALLOC_RX;
            else
            begin
                off = (OFF_W'(fr) << sh) + inner;
                len = LEN_W'($urandom_range(1, 32'(fsize - inner)));
            end
        end
        else if (pick >= 65 && pick < 75)
        begin
            // Release any frame of the area: free, or held by either side
            fn  = $urandom_range(0, 1) ? FN_REL_TX : FN_REL_RX;
            fr  = $urandom_range(0, cnt - 1);
            off = (OFF_W'(fr) << sh) + inner;
            len = 32'd1;
        end
        else if (pick >= 75 && pick < 82)
        begin
            // Receive release of a held frame with zero length or a crossing span
            fn = FN_REL_RX;
            fr = find_marked(OWN_RX);
            if (fr < 0)
                fr = $urandom_range(0, cnt - 1);
            off = (OFF_W'(fr) << sh) + inner;
            if ($urandom_range(0, 2) == 0)
                len = '0;
            else
                len = LEN_W'(fsize - inner) + $urandom_range(0, 32'(fsize * 3));
        end
        else if (pick >= 82 && pick < 88)
        begin
            // Just past the end of the area, or far beyond it
            fn = $urandom_range(0, 1) ? FN_REL_TX : FN_REL_RX;
            if ($urandom_range(0, 1) == 0)
                off = (OFF_W'(cnt) << sh) + OFF_W'($urandom_range(0, 32'(fsize * 4)));
            len = 32'd1;
        end
        else if (pick >= 88 && pick < 94)
        begin
            // Random function at a random offset inside the area
            fn  = 2'($urandom_range(0, 3));
            off = OFF_W'($urandom_range(0, 32'((OFF_W'(cnt) << sh) - 64'd1)));
        end
        else if (pick >= 94)
        begin
            // Pure noise on every field
            fn = 2'($urandom_range(0, 3));
        end
        send_request(fn, off, len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: 4096 frames of 4 KiB. The stack pops from the top,
    // so the first grants after a refill are frames 4095 and 4094.
    task automatic test_default_pool();
        send_request(FN_ALLOC_RX, '0, '0);
        send_request(FN_ALLOC_TX, '1, '1);
        // wrong owner: transmit frame released as a receive frame
        send_request(FN_REL_RX, 64'd4094 << 12, 32'd16);
        send_request(FN_REL_TX, (64'd4094 << 12) + 64'd4095, 32'd0);
        // double release of a frame that is already free
        send_request(FN_REL_TX, 64'd4094 << 12, 32'd0);
        send_request(FN_REL_RX, 64'd4095 << 12, 32'd0);
        send_request(FN_REL_RX, (64'd4095 << 12) + 64'd100, 32'd4096);
        // last byte wraps past the top of the 64-bit space
        send_request(FN_REL_RX, '1, 32'd2);
        send_request(FN_REL_RX, '1, 32'd1);
        send_request(FN_REL_TX, 64'd1 << 24, '1);
        send_request(FN_REL_TX, 64'h8000_0000_0000_0000, 32'd1);
        send_request(FN_REL_RX, '0, '1);
        send_request(FN_REL_RX, 64'd4095 << 12, 32'd4096);
        send_request(FN_REL_TX, '0, 32'd1);
    endtask

    // Count zero clamps to a single frame, shift zero to 64-byte frames;
    // run the pool dry and refill it
    task automatic test_single_frame_pool();
        write_register(CFG_FRAME_COUNT, '0);
        write_register(CFG_FRAME_SHIFT, 13'h1FE0);
        send_request(FN_ALLOC_TX, '0, '0);
        send_request(FN_ALLOC_RX, '0, '0);
        send_request(FN_REL_TX, 64'd63, 32'd1);
        send_request(FN_REL_RX, 64'd64, 32'd1);
        send_request(FN_ALLOC_RX, '1, '1);
        send_request(FN_REL_RX, '0, 32'd64);
    endtask

    // All-ones writes clamp to 64 KiB frames and the full memory depth
    task automatic test_saturated_registers();
        write_register(CFG_FRAME_SHIFT, '1);
        write_register(CFG_FRAME_COUNT, '1);
        send_request(FN_ALLOC_TX, '0, '0);
        send_request(FN_REL_TX, (64'd4095 << 16) + 64'd65535, 32'd0);
        send_request(FN_REL_TX, 64'd1 << 28, 32'd1);
        send_request(FN_ALLOC_RX, '0, '0);
        send_request(FN_REL_RX, 64'd4095 << 16, 32'd65536);
    endtask

    // Random traffic over a series of register settings, extremes included;
    // small pools make the empty case frequent
    task automatic test_random_traffic();
        logic [SHIFT_W-1:0] shift_pick;
        logic [COUNT_W-1:0] count_pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       begin shift_pick = 5'd6;  count_pick = 13'd1;    end
                1:       begin shift_pick = 5'd16; count_pick = 13'd2;    end
                2:       begin shift_pick = 5'd7;  count_pick = 13'd5;    end
                3:       begin shift_pick = 5'd9;  count_pick = 13'd16;   end
                4:       begin shift_pick = 5'd12; count_pick = 13'd4096; end
                5:
                begin
                    shift_pick = SHIFT_W'($urandom_range(0, 31));
                    count_pick = COUNT_W'($urandom_range(0, 8191));
                end
                6:
                begin
                    shift_pick = SHIFT_W'($urandom_range(SHIFT_LO, SHIFT_HI));
                    count_pick = COUNT_W'($urandom_range(1, 40));
                end
                default:
                begin
                    shift_pick = SHIFT_W'($urandom_range(SHIFT_LO, SHIFT_HI));
                    count_pick = COUNT_W'($urandom_range(2, 12));
                end
            endcase
            // upper data bits are don't-care for the shift register
            write_register(CFG_FRAME_SHIFT, {8'($urandom_range(0, 255)), shift_pick});
            write_register(CFG_FRAME_COUNT, count_pick);
            repeat (PHASE_ITEMS)
                random_request();
        end
    endtask

    initial
    begin
        refill_pool();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_default_pool();
        test_single_frame_pool();
        test_saturated_registers();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0)
            $display("frame_pool_allocator_checked_top_test: clean");
        else
            $display("frame_pool_allocator_checked_top_test: errors");
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #(TIMEOUT_CYCLES * (CLK_HIGH + CLK_LOW));
        $display("frame_pool_allocator_checked_top_test: errors");
        $finish;
    end

endmodule
